### src/fdfb_pkg.sv
// Shared types and constants for the flip-dot frame builder.
// No dependencies; used by fdfb_image, flip_dot_frame_builder_top and the testbench.
`default_nettype none

package fdfb_pkg;

    // Default panel geometry
    localparam int WIDTH_DEF  = 28;
    localparam int HEIGHT_DEF = 7;

    // One stored column word
    localparam int COL_W = 8;

    // Operation codes
    localparam logic [1:0] FUNC_SET    = 2'd0;
    localparam logic [1:0] FUNC_CLR    = 2'd1;
    localparam logic [1:0] FUNC_RENDER = 2'd2;

    // Frame bytes
    localparam logic [7:0] FRAME_HEADER    = 8'h80;
    localparam logic [7:0] FRAME_WRITE_CMD = 8'h83;
    localparam logic [7:0] FRAME_END       = 8'h8f;

    typedef struct packed {
        logic [1:0]         func;
        logic signed [15:0] col_x;
        logic signed [15:0] row_y;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out;

    // Control group from the sequencer to the image store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_img_ctl;

endpackage

`default_nettype wire

### src/flip_dot_frame_builder_top.sv
// Flip-dot frame builder top level: command sequencer around the column image store.
// Depends on fdfb_pkg and fdfb_image.
// Set pixel: busy after start for a read, then a read-modify-write. Clear: taken while idle, busy stays low.
// Render: WIDTH + 4 result bytes, one per cycle: header, write command, address, columns, end;
// busy until the end byte goes out, with the columns paced by the single image read port.
// Synchronous active-low reset clears the image and the address register; results cannot stall.
`default_nettype none

module flip_dot_frame_builder_top #(
    parameter int WIDTH  = fdfb_pkg::WIDTH_DEF,
    parameter int HEIGHT = fdfb_pkg::HEIGHT_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // command channel
    input  wire logic          start,
    output logic               busy,
    input  wire fdfb_pkg::t_in i_cmd,
    // result channel
    output logic               o_res_strobe,
    output fdfb_pkg::t_out     o_res,
    // configuration channel (panel address)
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [7:0]    i_cfg_data
);

    localparam int AW = (WIDTH > 1) ? $clog2(WIDTH) : 1;
    localparam logic [fdfb_pkg::COL_W-1:0] ROW_MASK =
        fdfb_pkg::COL_W'((9'd1 << HEIGHT) - 9'd1);
    localparam logic [AW-1:0] LAST_COL = AW'(WIDTH - 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_WR   = 3'd1;  // pixel read-modify-write
    localparam logic [2:0] S_HDR  = 3'd2;
    localparam logic [2:0] S_CMD  = 3'd3;
    localparam logic [2:0] S_ADR  = 3'd4;  // also issues read of column 0
    localparam logic [2:0] S_COL  = 3'd5;
    localparam logic [2:0] S_END  = 3'd6;

    logic [2:0]                   r_state, n_state;
    logic [7:0]                   r_addr_reg;
    logic [AW-1:0]                r_col, n_col;
    logic [fdfb_pkg::COL_W-1:0]   r_bit, n_bit;
    logic                         r_lit, n_lit;
    logic                         r_strobe, n_strobe;
    fdfb_pkg::t_out               r_res, n_res;

    fdfb_pkg::t_img_ctl           img_ctl;
    logic [AW-1:0]                rd_addr;
    logic [fdfb_pkg::COL_W-1:0]   rd_data;
    logic [fdfb_pkg::COL_W-1:0]   wr_data;

    logic                         accept;
    logic                         x_ok;
    logic                         y_ok;

    assign accept = start && (r_state == S_IDLE);

    // Coordinates on the panel: nonnegative and below the panel size
    assign x_ok = !i_cmd.col_x[15] && ({1'b0, i_cmd.col_x[14:0]} < 16'(WIDTH));
    assign y_ok = !i_cmd.row_y[15] && ({1'b0, i_cmd.row_y[14:0]} < 16'(HEIGHT));

    // Read-modify-write value; data from the store is already masked
    assign wr_data = (r_lit ? (rd_data | r_bit) : (rd_data & ~r_bit)) & ROW_MASK;

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_bit       = r_bit;
        n_lit       = r_lit;
        n_strobe    = 1'b0;
        n_res       = r_res;
        img_ctl     = '0;
        rd_addr     = r_col;

        case (r_state)
            S_IDLE: begin
                rd_addr = i_cmd.col_x[AW-1:0];
                if (accept) begin
                    case (i_cmd.func)
                        fdfb_pkg::FUNC_SET: begin
                            if (x_ok && y_ok) begin
                                img_ctl.rd_en = 1'b1;
                                n_col   = i_cmd.col_x[AW-1:0];
                                n_bit   = fdfb_pkg::COL_W'(1) << i_cmd.row_y[2:0];
                                n_lit   = |(i_cmd.red | i_cmd.green | i_cmd.blue);
                                n_state = S_WR;
                            end
                        end
                        fdfb_pkg::FUNC_CLR: begin
                            img_ctl.clr = 1'b1;
                        end
                        fdfb_pkg::FUNC_RENDER: begin
                            n_state = S_HDR;
                        end
                        default: begin
                            // unused code: ignored
                        end
                    endcase
                end
            end
            S_WR: begin
                img_ctl.wr_en = 1'b1;
                n_state       = S_IDLE;
            end
            S_HDR: begin
                n_strobe = 1'b1;
                n_res    = '{out_byte: fdfb_pkg::FRAME_HEADER, last: 1'b0};
                n_state  = S_CMD;
            end
            S_CMD: begin
                n_strobe = 1'b1;
                n_res    = '{out_byte: fdfb_pkg::FRAME_WRITE_CMD, last: 1'b0};
                n_state  = S_ADR;
            end
            S_ADR: begin
                n_strobe      = 1'b1;
                n_res         = '{out_byte: r_addr_reg, last: 1'b0};
                img_ctl.rd_en = 1'b1;
                rd_addr       = '0;
                n_col         = '0;
                n_state       = S_COL;
            end
            S_COL: begin
                n_strobe = 1'b1;
                n_res    = '{out_byte: 8'(rd_data & ROW_MASK), last: 1'b0};
                if (r_col == LAST_COL) begin
                    n_state = S_END;
                end else begin
                    img_ctl.rd_en = 1'b1;
                    rd_addr       = r_col + AW'(1);
                    n_col         = r_col + AW'(1);
                end
            end
            S_END: begin
                n_strobe = 1'b1;
                n_res    = '{out_byte: fdfb_pkg::FRAME_END, last: 1'b1};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_strobe   <= 1'b0;
            r_addr_reg <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                r_addr_reg <= i_cfg_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_col <= n_col;
        r_bit <= n_bit;
        r_lit <= n_lit;
        r_res <= n_res;
    end

    fdfb_image #(
        .WIDTH (WIDTH),
        .AW    (AW)
    ) u_image (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (img_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (r_col),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    assign busy         = (r_state != S_IDLE);
    assign o_cfg_ready  = (r_state == S_IDLE);
    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

endmodule

`default_nettype wire

### src/fdfb_image.sv
// Column image store: one word per column, registered read, valid bit per entry.
// Depends on fdfb_pkg.
`default_nettype none

module fdfb_image #(
    parameter int WIDTH = fdfb_pkg::WIDTH_DEF,
    parameter int AW    = 5
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire fdfb_pkg::t_img_ctl        i_ctl,
    input  wire logic [AW-1:0]             i_rd_addr,
    input  wire logic [AW-1:0]             i_wr_addr,
    input  wire logic [fdfb_pkg::COL_W-1:0] i_wr_data,
    output logic [fdfb_pkg::COL_W-1:0]     o_rd_data
);

    logic [fdfb_pkg::COL_W-1:0] r_mem [WIDTH];
    logic [WIDTH-1:0]           r_vld;
    logic [fdfb_pkg::COL_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    // Storage, no reset
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Valid bits: an entry never written since the last clear reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.clr) begin
                r_vld <= '0;
            end else if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for flip_dot_frame_builder_top: random and directed commands,
// an in-bench image predictor and an in-order frame byte scoreboard.
// Depends on fdfb_pkg and the RTL under src/.

// Tracks the panel image and address, queues the frame bytes each render must produce.
class frame_board;
    localparam int COLS = fdfb_pkg::WIDTH_DEF;
    localparam int ROWS = fdfb_pkg::HEIGHT_DEF;

    logic [7:0]       image [COLS];
    logic [7:0]       panel_addr;
    fdfb_pkg::t_out   frame_bytes[$];
    int               bad_bytes;

    function new();
        foreach (image[i]) image[i] = '0;
        panel_addr = '0;
        bad_bytes  = 0;
    endfunction

    function void set_addr(logic [7:0] a);
        panel_addr = a;
    endfunction

    function int pending();
        return frame_bytes.size();
    endfunction

    function void push_byte(logic [7:0] b, logic is_last);
        fdfb_pkg::t_out r;
        r.out_byte = b;
        r.last     = is_last;
        frame_bytes.push_back(r);
    endfunction

    // Accepted command: update the image or snapshot a whole frame.
    function void take_cmd(fdfb_pkg::t_in c);
        int col;
        int row;
        col = c.col_x;
        row = c.row_y;
        case (c.func)
            fdfb_pkg::FUNC_SET: begin
                if (col >= 0 && col < COLS && row >= 0 && row < ROWS)
                    image[col][row] = |{c.red, c.green, c.blue};
            end
            fdfb_pkg::FUNC_CLR: begin
                foreach (image[i]) image[i] = '0;
            end
            fdfb_pkg::FUNC_RENDER: begin
                push_byte(fdfb_pkg::FRAME_HEADER, 1'b0);
                push_byte(fdfb_pkg::FRAME_WRITE_CMD, 1'b0);
                push_byte(panel_addr, 1'b0);
                foreach (image[i]) push_byte(image[i], 1'b0);
                push_byte(fdfb_pkg::FRAME_END, 1'b1);
            end
            default: ;
        endcase
    endfunction

    function void fail(string what);
        bad_bytes++;
        if (bad_bytes <= 10) $display("%0t: %s", $time, what);
    endfunction

    function void check_byte(fdfb_pkg::t_out got);
        fdfb_pkg::t_out want;
        if (frame_bytes.size() == 0) begin
            fail($sformatf("unexpected byte %02h last %0b", got.out_byte, got.last));
            return;
        end
        want = frame_bytes.pop_front();
        if (got.out_byte !== want.out_byte)
            fail($sformatf("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte));
        if (got.last !== want.last)
            fail($sformatf("last: expected %0b, got %0b", want.last, got.last));
    endfunction
endclass

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fdfb_pkg::*;

    localparam int WIDTH  = WIDTH_DEF;
    localparam int HEIGHT = HEIGHT_DEF;
    // code 3 has no operation behind it; the block must ignore it
    localparam logic [1:0] FUNC_NONE = 2'd3;
    // cycles with no transfer of any kind before the run is declared hung
    localparam int QUIET_LIMIT = 1000;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 68;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic start       = 1'b0;
    logic busy;
    t_in  i_cmd       = '0;
    logic o_res_strobe;
    t_out o_res;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data  = '0;

    frame_board sb = new();

    // sender idles between commands unless a back-to-back burst is running
    bit burst = 1'b0;
    int quiet = 0;

    flip_dot_frame_builder_top #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .o_res_strobe (o_res_strobe),
        .o_res        (o_res),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Result side: every strobed byte is a transfer, the receiver never stalls.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_strobe) sb.check_byte(o_res);
    end

    // Watchdog: any command, result or config transfer counts as progress.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_strobe || (i_cfg_valid && o_cfg_ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // One command transfer. Called at a clock edge; start stays high on return so
    // a zero gap gives back-to-back commands without dropping start.
    task automatic send_cmd(t_in c, int unsigned gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        sb.take_cmd(c);
    endtask

    // Lower start and wait until every queued frame byte has come out, then let
    // the block finish a trailing pixel write that has no result.
    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Address write; only issued while the block is idle.
    task automatic write_addr(logic [7:0] a);
        repeat ($urandom_range(0, 8)) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= a;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_addr(a);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= 8'($urandom());
    endtask

    function automatic t_in pixel(int x, int y, int r, int g, int b);
        t_in c;
        c.func  = FUNC_SET;
        c.col_x = 16'(x);
        c.row_y = 16'(y);
        c.red   = 8'(r);
        c.green = 8'(g);
        c.blue  = 8'(b);
        return c;
    endfunction

    // Non-pixel command; the coordinate and color fields carry noise.
    function automatic t_in op(logic [1:0] f);
        t_in c;
        c = t_in'({$urandom(), $urandom(), $urandom()});
        c.func = f;
        return c;
    endfunction

    // Mostly on-panel pixel writes so frames carry real content; a share of
    // full-range coordinates, clears, renders and the unused code.
    function automatic t_in rand_cmd();
        t_in c;
        int unsigned pick;
        int unsigned tint;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            c = pixel($urandom_range(0, WIDTH - 1), $urandom_range(0, HEIGHT - 1), 0, 0, 0);
            if ($urandom_range(0, 6) == 0) c.col_x = 16'($urandom());
            if ($urandom_range(0, 6) == 0) c.row_y = 16'($urandom());
            tint = $urandom_range(0, 3);
            case (tint)
                0: ;                              // dark: clears the dot
                1: c.red   = 8'($urandom_range(1, 255));
                2: c.green = 8'($urandom_range(1, 255));
                default: begin
                    c.red   = 8'($urandom());
                    c.green = 8'($urandom());
                    c.blue  = 8'($urandom());
                end
            endcase
            if (tint != 0 && $urandom_range(0, 3) == 0) c.blue = 8'($urandom_range(1, 255));
        end else if (pick < 78) begin
            c = op(FUNC_CLR);
        end else if (pick < 95) begin
            c = op(FUNC_RENDER);
        end else begin
            c = op(FUNC_NONE);
        end
        return c;
    endfunction

    function automatic int unsigned next_gap();
        if ($urandom_range(0, 15) == 0) burst = !burst;
        return burst ? 0 : $urandom_range(0, 8);
    endfunction

    initial begin
        logic [7:0] addr_plan[PHASES];

        addr_plan = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00};
        addr_plan[2] = 8'($urandom());
        addr_plan[4] = 8'($urandom());
        addr_plan[5] = 8'($urandom());

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_addr(8'h00);

        // Directed: empty frame, the four panel corners with each color channel,
        // every off-panel edge, the unused code, dark pixels, clear, back-to-back.
        send_cmd(op(FUNC_RENDER), 0);
        send_cmd(pixel(0, 0, 255, 0, 0), 0);
        send_cmd(pixel(WIDTH - 1, HEIGHT - 1, 0, 1, 0), 0);
        send_cmd(pixel(0, HEIGHT - 1, 0, 0, 128), 2);
        send_cmd(pixel(WIDTH - 1, 0, 255, 255, 255), 0);
        send_cmd(pixel(13, 3, 1, 0, 0), 1);
        send_cmd(pixel(-1, 0, 255, 255, 255), 0);
        send_cmd(pixel(WIDTH, 0, 255, 255, 255), 0);
        send_cmd(pixel(0, HEIGHT, 255, 255, 255), 0);
        send_cmd(pixel(0, -1, 255, 255, 255), 0);
        send_cmd(pixel(-32768, 32767, 255, 255, 255), 0);
        send_cmd(pixel(32767, -32768, 255, 255, 255), 0);
        send_cmd(op(FUNC_NONE), 0);
        send_cmd(op(FUNC_RENDER), 0);
        send_cmd(pixel(13, 3, 0, 0, 0), 0);
        send_cmd(pixel(WIDTH - 1, HEIGHT - 1, 0, 0, 0), 0);
        send_cmd(op(FUNC_RENDER), 0);
        send_cmd(op(FUNC_RENDER), 0);
        send_cmd(op(FUNC_CLR), 0);
        send_cmd(op(FUNC_RENDER), 3);
        send_cmd(pixel(5, 5, 7, 0, 0), 0);
        send_cmd(op(FUNC_RENDER), 0);
        drain();

        // Random phases, one address setting each; the drain before each write
        // is also the sender's pause until all frame bytes are out.
        foreach (addr_plan[p]) begin
            write_addr(addr_plan[p]);
            repeat (PHASE_ITEMS) send_cmd(rand_cmd(), next_gap());
            drain();
        end

        repeat (WIDTH + 8) @(posedge i_clk);
        if (sb.pending() != 0) sb.fail("frame bytes never produced");

        if (sb.bad_bytes == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
